[hw/rtl/iqmh_pkg.sv]
package iqmh_pkg;

    localparam int MaxEntries = 1024;
    localparam int ValueWidth = 16;
    localparam int PolyWidth  = 10;
    localparam int CountWidth = 11;

    localparam logic FuncAppend = 1'b0;
    localparam logic FuncUpdate = 1'b1;

    localparam logic [1:0] StatusOk      = 2'd0;
    localparam logic [1:0] StatusFull    = 2'd1;
    localparam logic [1:0] StatusUnknown = 2'd2;

    typedef struct packed {
        logic                         func;
        logic [PolyWidth-1:0]         polygon;
        logic signed [ValueWidth-1:0] order_key;
        logic signed [ValueWidth-1:0] quality;
        logic                         is_fixed;
    } cmd_t;

    typedef struct packed {
        logic [PolyWidth-1:0]         top_polygon;
        logic signed [ValueWidth-1:0] top_key;
        logic signed [ValueWidth-1:0] min_free_quality;
        logic                         min_defined;
        logic                         any_invalid;
        logic [CountWidth-1:0]        entry_count;
        logic [1:0]                   status;
    } res_t;

endpackage

[hw/rtl/iqmh_store.sv]
module iqmh_store #(
    parameter int MAX_ENTRIES = iqmh_pkg::MaxEntries,
    parameter int VALUE_WIDTH = iqmh_pkg::ValueWidth,
    localparam int AW = $clog2(MAX_ENTRIES),
    localparam int EW = AW + 2 * VALUE_WIDTH + 1
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [EW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [EW-1:0] rdata
);

    logic [EW-1:0] mem [MAX_ENTRIES];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[hw/rtl/iqmh_map.sv]
module iqmh_map #(
    parameter int MAX_ENTRIES = iqmh_pkg::MaxEntries,
    localparam int AW = $clog2(MAX_ENTRIES)
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [AW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [AW-1:0] rdata
);

    logic [AW-1:0] mem [MAX_ENTRIES];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[hw/rtl/indexed_quality_min_heap.sv]
// steps: an update reads the map and slot; a valid command writes the entry and sifts
// it up (UPRD, UPWT, UPCMP, SWA, SWB per level) and down (DNRDL, DNRDR, DNWL, DNCMP,
// SWA, SWB per level); every command then scans all stored entries for the quality
// minimum, which sets the rate; one command at a time, busy is high until the strobe
// reset: count clears to zero, slot and map memories stay undefined until written
// the receiver cannot stall: result is shown for exactly one cycle with done
module indexed_quality_min_heap #(
    parameter int MAX_ENTRIES = iqmh_pkg::MaxEntries,
    parameter int VALUE_WIDTH = iqmh_pkg::ValueWidth
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  iqmh_pkg::cmd_t  cmd,
    output logic            busy,
    output logic            done,
    output iqmh_pkg::res_t  res
);

    localparam int AW = $clog2(MAX_ENTRIES);
    localparam int CW = AW + 1;
    localparam int VW = VALUE_WIDTH;
    localparam int EW = AW + 2 * VW + 1;
    localparam int PW = iqmh_pkg::PolyWidth;
    localparam int OW = iqmh_pkg::ValueWidth;
    localparam int NW = iqmh_pkg::CountWidth;

    typedef enum logic [4:0] {
        S_IDLE, S_MAPRD, S_MAPWT, S_POSRD, S_POSWT, S_POSWR,
        S_UPRD, S_UPWT, S_UPCMP,
        S_DNRDL, S_DNRDR, S_DNWL, S_DNCMP,
        S_SWA, S_SWB,
        S_SCAN, S_SCWT, S_DONE
    } state_t;

    typedef struct packed {
        logic [AW-1:0]        poly;
        logic signed [VW-1:0] key;
        logic signed [VW-1:0] qual;
        logic                 fixed;
    } ent_t;

    state_t state_reg;
    logic [CW-1:0] count_reg;
    logic [AW-1:0] pos_reg, other_reg, scan_reg;
    logic [CW-1:0] scan_cnt_reg;
    logic          dir_down_reg;
    ent_t cur_reg, oth_reg, left_reg;
    logic          has_right_reg;
    logic [1:0]    status_reg;
    logic [AW-1:0] poly_reg;
    logic signed [VW-1:0] key_in_reg, qual_in_reg;
    logic signed [VW-1:0] minq_reg;
    logic          def_reg, inv_reg, scan_last_reg;
    logic [PW-1:0] top_poly_reg;
    logic signed [VW-1:0] top_key_reg;
    logic          done_reg;

    logic          s_we;
    logic [AW-1:0] s_waddr, s_raddr;
    ent_t          s_wdata, s_rdata;
    logic [EW-1:0] s_rraw;
    logic          m_we;
    logic [AW-1:0] m_waddr, m_wdata, m_raddr, m_rdata;

    iqmh_store #(.MAX_ENTRIES(MAX_ENTRIES), .VALUE_WIDTH(VALUE_WIDTH)) u_store (
        .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
        .raddr(s_raddr), .rdata(s_rraw)
    );
    assign s_rdata = s_rraw;

    iqmh_map #(.MAX_ENTRIES(MAX_ENTRIES)) u_map (
        .clk(clk), .we(m_we), .waddr(m_waddr), .wdata(m_wdata),
        .raddr(m_raddr), .rdata(m_rdata)
    );

    logic [CW-1:0] left_idx, right_idx;
    logic [AW-1:0] parent_idx;
    assign left_idx   = {pos_reg, 1'b1};
    assign right_idx  = left_idx + CW'(1);
    assign parent_idx = AW'((pos_reg - AW'(1)) >> 1);

    always_comb
    begin
        s_we    = 1'b0;
        s_waddr = pos_reg;
        s_wdata = cur_reg;
        s_raddr = pos_reg;
        m_we    = 1'b0;
        m_waddr = cur_reg.poly;
        m_wdata = pos_reg;
        m_raddr = poly_reg;
        case (state_reg)
            S_POSWR:
            begin
                s_we = 1'b1;
                m_we = 1'b1;
            end
            S_UPRD:  s_raddr = parent_idx;
            S_UPWT:  s_raddr = parent_idx;
            S_DNRDL: s_raddr = left_idx[AW-1:0];
            S_DNRDR: s_raddr = right_idx[AW-1:0];
            S_DNWL:  s_raddr = right_idx[AW-1:0];
            S_SWA:
            begin
                s_we    = 1'b1;
                s_waddr = other_reg;
                m_we    = 1'b1;
                m_waddr = cur_reg.poly;
                m_wdata = other_reg;
            end
            S_SWB:
            begin
                s_we    = 1'b1;
                s_wdata = oth_reg;
                m_we    = 1'b1;
                m_waddr = oth_reg.poly;
            end
            S_SCAN:  s_raddr = scan_reg;
            S_SCWT:  s_raddr = scan_reg;
            default: ;
        endcase
    end

    ent_t pick;
    logic [AW-1:0] pick_idx;
    always_comb
    begin
        pick     = left_reg;
        pick_idx = left_idx[AW-1:0];
        if (has_right_reg && (s_rdata.key < left_reg.key))
        begin
            pick     = s_rdata;
            pick_idx = right_idx[AW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        poly_reg     <= AW'(cmd.polygon);
                        key_in_reg   <= VW'(cmd.order_key);
                        qual_in_reg  <= VW'(cmd.quality);
                        status_reg   <= iqmh_pkg::StatusOk;
                        if (cmd.func == iqmh_pkg::FuncAppend)
                        begin
                            if (count_reg == CW'(MAX_ENTRIES))
                            begin
                                status_reg <= iqmh_pkg::StatusFull;
                                state_reg  <= S_SCAN;
                            end
                            else
                            begin
                                pos_reg       <= count_reg[AW-1:0];
                                cur_reg.poly  <= count_reg[AW-1:0];
                                cur_reg.key   <= VW'(cmd.order_key);
                                cur_reg.qual  <= VW'(cmd.quality);
                                cur_reg.fixed <= cmd.is_fixed;
                                count_reg     <= count_reg + CW'(1);
                                state_reg     <= S_POSWR;
                            end
                        end
                        else if (CW'(cmd.polygon) >= count_reg)
                        begin
                            status_reg <= iqmh_pkg::StatusUnknown;
                            state_reg  <= S_SCAN;
                        end
                        else
                        begin
                            state_reg <= S_MAPRD;
                        end
                        scan_reg      <= '0;
                        scan_cnt_reg  <= '0;
                        dir_down_reg  <= 1'b0;
                    end
                end
                S_MAPRD: state_reg <= S_MAPWT;
                S_MAPWT:
                begin
                    pos_reg   <= m_rdata;
                    state_reg <= S_POSRD;
                end
                S_POSRD: state_reg <= S_POSWT;
                S_POSWT:
                begin
                    cur_reg.poly  <= s_rdata.poly;
                    cur_reg.fixed <= s_rdata.fixed;
                    cur_reg.key   <= key_in_reg;
                    cur_reg.qual  <= qual_in_reg;
                    state_reg     <= S_POSWR;
                end
                S_POSWR: state_reg <= (pos_reg == '0) ? S_DNRDL : S_UPRD;
                S_UPRD:  state_reg <= S_UPWT;
                S_UPWT:  state_reg <= S_UPCMP;
                S_UPCMP:
                begin
                    if (s_rdata.key < cur_reg.key)
                    begin
                        state_reg <= S_DNRDL;
                    end
                    else
                    begin
                        oth_reg      <= s_rdata;
                        other_reg    <= parent_idx;
                        dir_down_reg <= 1'b0;
                        state_reg    <= S_SWA;
                    end
                end
                S_DNRDL:
                begin
                    dir_down_reg <= 1'b1;
                    if (left_idx >= count_reg)
                    begin
                        state_reg <= S_SCAN;
                    end
                    else
                    begin
                        has_right_reg <= right_idx < count_reg;
                        state_reg     <= S_DNRDR;
                    end
                end
                S_DNRDR:
                begin
                    left_reg  <= s_rdata;
                    state_reg <= S_DNWL;
                end
                S_DNWL:  state_reg <= S_DNCMP;
                S_DNCMP:
                begin
                    if (pick.key < cur_reg.key)
                    begin
                        oth_reg   <= pick;
                        other_reg <= pick_idx;
                        state_reg <= S_SWA;
                    end
                    else
                    begin
                        state_reg <= S_SCAN;
                    end
                end
                S_SWA: state_reg <= S_SWB;
                S_SWB:
                begin
                    pos_reg   <= other_reg;
                    if (dir_down_reg)
                    begin
                        state_reg <= S_DNRDL;
                    end
                    else
                    begin
                        state_reg <= (other_reg == '0) ? S_DNRDL : S_UPRD;
                    end
                end
                S_SCAN:
                begin
                    def_reg       <= 1'b0;
                    inv_reg       <= 1'b0;
                    minq_reg      <= '0;
                    scan_last_reg <= (count_reg == '0);
                    scan_reg      <= AW'(1);
                    scan_cnt_reg  <= CW'(1);
                    state_reg     <= S_SCWT;
                end
                S_SCWT:
                begin
                    if (scan_last_reg)
                    begin
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        if (scan_cnt_reg == CW'(1))
                        begin
                            top_poly_reg <= PW'(s_rdata.poly);
                            top_key_reg  <= s_rdata.key;
                        end
                        if (s_rdata.qual < 0)
                        begin
                            inv_reg <= 1'b1;
                        end
                        if (!s_rdata.fixed && (!def_reg || s_rdata.qual < minq_reg))
                        begin
                            minq_reg <= s_rdata.qual;
                            def_reg  <= 1'b1;
                        end
                        scan_last_reg <= (scan_cnt_reg >= count_reg);
                        scan_reg      <= scan_reg + AW'(1);
                        scan_cnt_reg  <= scan_cnt_reg + CW'(1);
                    end
                end
                S_DONE:
                begin
                    done_reg  <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign done = done_reg;
    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        res = '0;
        res.entry_count = NW'(count_reg);
        res.status      = status_reg;
        res.min_defined = def_reg;
        res.any_invalid = inv_reg;
        if (count_reg != '0)
        begin
            res.top_polygon = top_poly_reg;
            res.top_key     = OW'(top_key_reg);
        end
        if (def_reg)
        begin
            res.min_free_quality = OW'(minq_reg);
        end
        if (!done_reg)
        begin
            res = '0;
        end
    end

endmodule

[hw/rtl/iqmh_check.sv]
module iqmh_check (
    input logic           clk,
    input logic           rst_n,
    input logic           start,
    input logic           busy,
    input logic           done,
    input iqmh_pkg::res_t res
);

    a_done_ends_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy) else $error("done while busy");

    a_start_sets_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy) else $error("start not taken");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done) else $error("done held");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (res.status == iqmh_pkg::StatusOk || res.status == iqmh_pkg::StatusFull
                  || res.status == iqmh_pkg::StatusUnknown)) else $error("bad status");

endmodule

bind indexed_quality_min_heap iqmh_check u_check (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .done(done), .res(res)
);

[sim/tb.sv]
`timescale 1ns / 1ps

module tb;

    logic clk;
    logic rst_n;
    logic start;
    iqmh_pkg::cmd_t cmd;
    logic busy;
    logic done;
    iqmh_pkg::res_t res;

    indexed_quality_min_heap uut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done),
        .res   (res)
    );

    // heap model
    logic [iqmh_pkg::PolyWidth-1:0]         hp_poly [iqmh_pkg::MaxEntries];
    logic signed [iqmh_pkg::ValueWidth-1:0] hp_key  [iqmh_pkg::MaxEntries];
    logic signed [iqmh_pkg::ValueWidth-1:0] hp_qual [iqmh_pkg::MaxEntries];
    logic                                   hp_fix  [iqmh_pkg::MaxEntries];
    int                                     pos_of  [iqmh_pkg::MaxEntries];
    int                                     heap_count;

    iqmh_pkg::cmd_t pending_cmds[$];
    iqmh_pkg::res_t expected_res[$];
    int   errors;
    int   n_results;
    bit   quiet;
    int   gap;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void swap_slots(int a, int b);
        logic [iqmh_pkg::PolyWidth-1:0]         tp;
        logic signed [iqmh_pkg::ValueWidth-1:0] tk;
        logic signed [iqmh_pkg::ValueWidth-1:0] tq;
        logic                                   tf;
        tp = hp_poly[a]; tk = hp_key[a]; tq = hp_qual[a]; tf = hp_fix[a];
        hp_poly[a] = hp_poly[b]; hp_key[a] = hp_key[b];
        hp_qual[a] = hp_qual[b]; hp_fix[a] = hp_fix[b];
        hp_poly[b] = tp; hp_key[b] = tk; hp_qual[b] = tq; hp_fix[b] = tf;
        pos_of[hp_poly[a]] = a;
        pos_of[hp_poly[b]] = b;
    endfunction

    function automatic void resift(int p);
        int par;
        int l;
        int pick;
        while (p > 0)
        begin
            par = (p - 1) / 2;
            if (hp_key[par] < hp_key[p])
                break;
            swap_slots(par, p);
            p = par;
        end
        while (1)
        begin
            l = 2 * p + 1;
            if (l >= heap_count)
                break;
            pick = l;
            if (l + 1 < heap_count && hp_key[l + 1] < hp_key[l])
                pick = l + 1;
            if (!(hp_key[pick] < hp_key[p]))
                break;
            swap_slots(pick, p);
            p = pick;
        end
    endfunction

    function automatic iqmh_pkg::res_t heap_apply(iqmh_pkg::cmd_t c);
        iqmh_pkg::res_t r;
        int   p;
        bit   defd;
        logic signed [iqmh_pkg::ValueWidth-1:0] mq;
        r = '0;
        r.status = iqmh_pkg::StatusOk;
        if (c.func == iqmh_pkg::FuncAppend)
        begin
            if (heap_count >= iqmh_pkg::MaxEntries)
                r.status = iqmh_pkg::StatusFull;
            else
            begin
                p = heap_count;
                hp_poly[p] = p[iqmh_pkg::PolyWidth-1:0];
                hp_key[p] = c.order_key;
                hp_qual[p] = c.quality;
                hp_fix[p] = c.is_fixed;
                pos_of[p] = p;
                heap_count++;
                resift(p);
            end
        end
        else if (c.polygon >= heap_count)
            r.status = iqmh_pkg::StatusUnknown;
        else
        begin
            p = pos_of[c.polygon];
            hp_key[p] = c.order_key;
            hp_qual[p] = c.quality;
            resift(p);
        end
        defd = 0;
        mq = '0;
        for (int i = 0; i < heap_count; i++)
        begin
            if (hp_qual[i] < 0)
                r.any_invalid = 1'b1;
            if (!hp_fix[i] && (!defd || hp_qual[i] < mq))
            begin
                mq = hp_qual[i];
                defd = 1;
            end
        end
        if (heap_count > 0)
        begin
            r.top_polygon = hp_poly[0];
            r.top_key = hp_key[0];
        end
        r.min_free_quality = defd ? mq : '0;
        r.min_defined = defd;
        r.entry_count = heap_count[iqmh_pkg::CountWidth-1:0];
        return r;
    endfunction

    // driver
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            gap = 0;
        end
        else if (start && !busy)
            start <= 1'b0;
        else if (!start && !busy && pending_cmds.size() > 0)
        begin
            if (gap > 0)
                gap--;
            else
            begin
                cmd <= pending_cmds.pop_front();
                start <= 1'b1;
                if (!quiet && $urandom_range(0, 2) == 0)
                    gap = $urandom_range(1, 5);
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
                expected_res.push_back(heap_apply(cmd));
            if (done)
            begin
                n_results++;
                if (expected_res.size() == 0)
                begin
                    $error("result transfer with nothing expected");
                    errors++;
                end
                else
                begin
                    iqmh_pkg::res_t e;
                    e = expected_res.pop_front();
                    if (res.top_polygon !== e.top_polygon)
                    begin
                        $error("top_polygon exp %0d got %0d", e.top_polygon, res.top_polygon);
                        errors++;
                    end
                    if (res.top_key !== e.top_key)
                    begin
                        $error("top_key exp %0d got %0d", e.top_key, res.top_key);
                        errors++;
                    end
                    if (res.min_free_quality !== e.min_free_quality)
                    begin
                        $error("min_free_quality exp %0d got %0d",
                               e.min_free_quality, res.min_free_quality);
                        errors++;
                    end
                    if (res.min_defined !== e.min_defined)
                    begin
                        $error("min_defined exp %0b got %0b", e.min_defined, res.min_defined);
                        errors++;
                    end
                    if (res.any_invalid !== e.any_invalid)
                    begin
                        $error("any_invalid exp %0b got %0b", e.any_invalid, res.any_invalid);
                        errors++;
                    end
                    if (res.entry_count !== e.entry_count)
                    begin
                        $error("entry_count exp %0d got %0d", e.entry_count, res.entry_count);
                        errors++;
                    end
                    if (res.status !== e.status)
                    begin
                        $error("status exp %0d got %0d", e.status, res.status);
                        errors++;
                    end
                end
            end
        end
    end

    function automatic iqmh_pkg::cmd_t mk(logic f, int poly, int k, int q, logic fx);
        iqmh_pkg::cmd_t c;
        c.func = f;
        c.polygon = poly[iqmh_pkg::PolyWidth-1:0];
        c.order_key = k[iqmh_pkg::ValueWidth-1:0];
        c.quality = q[iqmh_pkg::ValueWidth-1:0];
        c.is_fixed = fx;
        return c;
    endfunction

    function automatic iqmh_pkg::cmd_t rand_cmd(logic f, int maxp);
        iqmh_pkg::cmd_t c;
        c = mk(f, $urandom_range(0, maxp), $urandom, $urandom, 1'($urandom_range(0, 1)));
        if ($urandom_range(0, 7) == 0)
            c.order_key = iqmh_pkg::ValueWidth'($urandom_range(0, 3));
        return c;
    endfunction

    task automatic wait_drained();
        while (pending_cmds.size() > 0 || start || busy || expected_res.size() > 0)
            @(posedge clk);
    endtask

    initial
    begin
        errors = 0;
        n_results = 0;
        quiet = 0;
        heap_count = 0;
        clk = 1'b0;
        start = 1'b0;
        cmd = '0;
        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty heap cases, extremes, ties, fixed entries
        pending_cmds.push_back(mk(iqmh_pkg::FuncUpdate, 0, 0, 0, 0));
        pending_cmds.push_back(mk(iqmh_pkg::FuncAppend, 1023, 32767, 32767, 1));
        pending_cmds.push_back(mk(iqmh_pkg::FuncAppend, 0, -32768, -32768, 0));
        pending_cmds.push_back(mk(iqmh_pkg::FuncAppend, 0, -32768, 16384, 0));
        pending_cmds.push_back(mk(iqmh_pkg::FuncAppend, 0, 0, 0, 1));
        pending_cmds.push_back(mk(iqmh_pkg::FuncUpdate, 1, 32767, 100, 1));
        pending_cmds.push_back(mk(iqmh_pkg::FuncUpdate, 0, -32768, -1, 0));
        pending_cmds.push_back(mk(iqmh_pkg::FuncUpdate, 4, 5, 5, 0));
        pending_cmds.push_back(mk(iqmh_pkg::FuncUpdate, 1023, 5, 5, 0));
        pending_cmds.push_back(mk(iqmh_pkg::FuncAppend, 0, 0, -32768, 1));
        pending_cmds.push_back(mk(iqmh_pkg::FuncUpdate, 2, 32767, 32767, 1));
        pending_cmds.push_back(mk(iqmh_pkg::FuncUpdate, 3, -1, 1, 0));
        wait_drained();

        // pause with nothing outstanding, then random with mostly valid updates
        for (int i = 0; i < 280; i++)
            pending_cmds.push_back(($urandom_range(0, 2) == 0)
                ? rand_cmd(iqmh_pkg::FuncAppend, 1023)
                : rand_cmd(iqmh_pkg::FuncUpdate, ($urandom_range(0, 9) == 0) ? 1023 : 30 + i / 3));
        wait_drained();

        quiet = 1;
        for (int i = 0; i < 248; i++)
            pending_cmds.push_back(($urandom_range(0, 9) == 0)
                ? rand_cmd(iqmh_pkg::FuncAppend, 1023)
                : rand_cmd(iqmh_pkg::FuncUpdate, 1023));
        wait_drained();
        repeat (50) @(posedge clk);

        $display("ran %0d results: empty heap, single entry, ties, unknown polygons,",
                 n_results);
        $display("updates at the key and quality extremes, fixed and invalid entries");
        if (errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        #40ms;
        $display("end of test: mismatches");
        $finish;
    end
endmodule

[files.f]
hw/rtl/iqmh_pkg.sv
hw/rtl/iqmh_store.sv
hw/rtl/iqmh_map.sv
hw/rtl/indexed_quality_min_heap.sv
hw/rtl/iqmh_check.sv
sim/tb.sv
